[hw/rtl/nsr_pkg.sv]
`timescale 1ns / 1ps

package nsr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int RAD_BITS  = 48;
	localparam int DIV_BITS  = RAD_BITS + FRAC_BITS;      // dividend bits, one per cycle
	localparam int EST_BITS  = 64;                        // estimate / quotient width
	localparam int CNT_BITS  = $clog2(DIV_BITS);
	localparam int ROOT_BITS = 32;
	localparam int TOL_BITS  = 16;
	localparam int CAP_BITS  = 6;
	localparam int CFG_BITS  = 16;

	localparam logic [EST_BITS-1:0] QUOT_LIMIT = {{(EST_BITS-63){1'b0}}, 1'b1, 62'd0};
	localparam logic [CAP_BITS-1:0] CAP_RESET  = CAP_BITS'(40);

	typedef enum logic [0:0] {
		REG_TOLERANCE = 1'b0,
		REG_ITER_CAP  = 1'b1
	} reg_index_t;

endpackage

[hw/rtl/newton_square_root_core.sv]
`timescale 1ns / 1ps
// A zero radicand is answered without a division; otherwise every Newton step runs
//   one full serial division of the 64-bit dividend.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// The serial divider (one quotient bit per cycle) sets the step length.
// Reset (arst_n low, asynchronous): idle, tolerance 0, iteration cap 40, no strobe.
// Results are strobed on done for one cycle; the receiver cannot stall.
module newton_square_root_core
	import nsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	output logic                 busy,
	input  logic [RAD_BITS-1:0]  radicand,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [0:0]           cfg_index,
	input  logic [CFG_BITS-1:0]  cfg_data,
	// result
	output logic                 done,
	output logic [ROOT_BITS-1:0] root,
	output logic [CAP_BITS-1:0]  steps_used,
	output logic                 cap_reached
);

	// one-hot sequencer: start divide, wait for quotient, add/halve, test
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_TEST = 4'b1000
	} state_t;

	state_t state_q;

	logic [TOL_BITS-1:0]  tol_q;
	logic [CAP_BITS-1:0]  cap_q;

	logic [RAD_BITS-1:0]  r_q;      // radicand held for the whole transaction
	logic [EST_BITS-1:0]  x_q;      // current estimate
	logic [EST_BITS-1:0]  nx_q;     // new estimate
	logic [CAP_BITS-1:0]  steps_q;
	logic                 div_go_q;

	logic                 done_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CAP_BITS-1:0]  steps_out_q;
	logic                 cap_out_q;

	logic                 div_done;
	logic [EST_BITS-1:0]  quot;
	logic [EST_BITS-1:0]  sum;
	logic [EST_BITS-1:0]  diff;
	logic                 rising;
	logic                 converged;
	logic                 stalled;
	logic                 at_cap;
	logic [CAP_BITS-1:0]  cap_eff;
	logic [EST_BITS-1:0]  result;
	logic [ROOT_BITS-1:0] result_sat;
	logic                 accept;

	// config registers; writes must only arrive while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_TOLERANCE: tol_q <= cfg_data[TOL_BITS-1:0];
				REG_ITER_CAP:  cap_q <= cfg_data[CAP_BITS-1:0];
				default:       ;
			endcase
		end
	end

	nsr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend ({r_q, {FRAC_BITS{1'b0}}}),
		.divisor  (x_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// x < 2^63 and quotient <= 2^62, so the sum never overflows
	assign sum = x_q + quot;

	// step decision
	assign rising    = (nx_q >= x_q);
	assign diff      = rising ? (nx_q - x_q) : (x_q - nx_q);
	assign converged = (diff <= {{(EST_BITS-TOL_BITS){1'b0}}, tol_q});
	assign stalled   = (steps_q >= CAP_BITS'(2)) && rising;
	assign cap_eff   = (cap_q == '0) ? CAP_BITS'(1) : cap_q;
	assign at_cap    = (steps_q >= cap_eff);

	// a stalled iteration keeps the smaller, older estimate
	assign result     = (!converged && stalled) ? x_q : nx_q;
	assign result_sat = (result[EST_BITS-1:ROOT_BITS] != '0) ? '1 : result[ROOT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (radicand == '0) begin
							done_q <= 1'b1;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (converged || stalled || at_cap) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					r_q         <= radicand;
					x_q         <= {{(EST_BITS-RAD_BITS){1'b0}}, radicand};
					steps_q     <= '0;
					root_q      <= '0;
					steps_out_q <= '0;
					cap_out_q   <= 1'b0;
				end
			end
			ST_DIV: ;
			ST_SUM: begin
				nx_q    <= {1'b0, sum[EST_BITS-1:1]};
				steps_q <= steps_q + 1'b1;
			end
			ST_TEST: begin
				root_q      <= result_sat;
				steps_out_q <= steps_q;
				cap_out_q   <= !converged && !stalled && at_cap;
				x_q         <= (nx_q == '0) ? EST_BITS'(1) : nx_q;
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign root        = root_q;
	assign steps_used  = steps_out_q;
	assign cap_reached = cap_out_q;

endmodule

[hw/rtl/nsr_divider.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; quotient saturates at QUOT_LIMIT.
module nsr_divider
	import nsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [EST_BITS-1:0] divisor,
	output logic                done,
	output logic [EST_BITS-1:0] quotient
);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0] sr_q;
	logic [EST_BITS-1:0] dvs_q;
	logic [EST_BITS-1:0] rem_q;
	logic [EST_BITS-1:0] quot_q;

	logic [EST_BITS-1:0] rem_sh;
	logic                fits;

	// remainder stays below the divisor (< 2^63), so the top bit is free
	assign rem_sh = {rem_q[EST_BITS-2:0], sr_q[DIV_BITS-1]};
	assign fits   = (rem_sh >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(DIV_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q   <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			sr_q   <= {sr_q[DIV_BITS-2:0], 1'b0};
			rem_q  <= fits ? (rem_sh - dvs_q) : rem_sh;
			quot_q <= {quot_q[EST_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = (quot_q > QUOT_LIMIT) ? QUOT_LIMIT : quot_q;

endmodule

[bench/tb_newton_square_root_core.sv]
`timescale 1ns / 1ps

// Bench for the fixed-point Newton square-root core.
// An initial block fills a list of jobs: radicands to root, and register writes that fall
// between phases. A clocked driver works through that list over the start/busy command
// handshake. At each accepted transaction it works out the expected root from its own copy
// of the tolerance and the iteration cap. A clocked monitor takes each done strobe and checks
// it against the oldest outstanding answer.
module tb_newton_square_root_core;
	import nsr_pkg::*;

	localparam int CLK_HALF       = 4;        // 8 ns period
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 4;        // idle cycles before a register write
	localparam int WATCHDOG_LIMIT = 30000;    // > worst-case transaction length + longest sender gap
	localparam int DRAIN_CYCLES   = 100;
	localparam int PHASE_ITEMS    = 50;
	localparam int RANDOM_PHASES  = 8;

	// why the iteration stopped; kept for the end-of-run summary only
	typedef enum logic [1:0] {
		STOP_ZERO,
		STOP_CONVERGED,
		STOP_RISING,
		STOP_CAP
	} stop_cause_t;

	typedef struct packed {
		logic [ROOT_BITS-1:0] root;
		logic [CAP_BITS-1:0]  steps;
		logic                 capped;
		stop_cause_t          cause;
	} root_answer_t;

	typedef enum logic {
		JOB_ROOT,
		JOB_WRITE
	} job_kind_t;

	typedef struct {
		job_kind_t          kind;
		logic [RAD_BITS-1:0] value;    // radicand, or register data in the low bits
		reg_index_t         index;
		int                 gap;       // sender idle cycles once this radicand is taken
	} job_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start;
	logic                 busy;
	logic [RAD_BITS-1:0]  radicand;
	logic                 cfg_wr_en;
	logic [0:0]           cfg_index;
	logic [CFG_BITS-1:0]  cfg_data;
	logic                 done;
	logic [ROOT_BITS-1:0] root;
	logic [CAP_BITS-1:0]  steps_used;
	logic                 cap_reached;

	job_t         pending_jobs[$];
	root_answer_t awaited_roots[$];

	// bench copy of the two registers, at their reset values
	logic [TOL_BITS-1:0] tol_now = '0;
	logic [CAP_BITS-1:0] cap_now = CAP_RESET;

	int gap_left;
	int quiet_cycles;
	int idle_cycles;
	int fails       = 0;
	int roots_taken = 0;
	int settings    = 1;
	int cause_count[4] = '{0, 0, 0, 0};

	newton_square_root_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.radicand    (radicand),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.root        (root),
		.steps_used  (steps_used),
		.cap_reached (cap_reached)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Babylonian iteration on the scaled radicand. The dividend R * 2^16 fills exactly
	// DIV_BITS, so a plain division saturated at QUOT_LIMIT gives the quotient.
	function automatic root_answer_t predict_root(input logic [RAD_BITS-1:0] rad,
			input logic [TOL_BITS-1:0] tol, input logic [CAP_BITS-1:0] cap_reg);
		root_answer_t        ans;
		logic [DIV_BITS-1:0] scaled;
		logic [EST_BITS-1:0] est, quot, next_est, delta, final_est;
		int unsigned         step_limit, n;
		ans = '{root: '0, steps: '0, capped: 1'b0, cause: STOP_ZERO};
		if (rad == '0)
			return ans;
		step_limit = (cap_reg == '0) ? 1 : cap_reg;   // a cap of zero still allows one step
		scaled     = {rad, {FRAC_BITS{1'b0}}};
		est        = EST_BITS'(rad);
		n          = 0;
		while (1'b1) begin
			quot = scaled / est;
			if (quot > QUOT_LIMIT)
				quot = QUOT_LIMIT;
			next_est = (est + quot) >> 1;
			delta    = (next_est >= est) ? next_est - est : est - next_est;
			n++;
			if (delta <= EST_BITS'(tol)) begin
				final_est = next_est;
				ans.cause = STOP_CONVERGED;
				break;
			end
			// an estimate that starts below the root rises on the first step only
			if (n >= 2 && next_est >= est) begin
				final_est = est;
				ans.cause = STOP_RISING;
				break;
			end
			if (n >= step_limit) begin
				final_est  = next_est;
				ans.capped = 1'b1;
				ans.cause  = STOP_CAP;
				break;
			end
			est = (next_est == '0) ? EST_BITS'(1) : next_est;
		end
		ans.root  = (final_est > EST_BITS'(32'hFFFF_FFFF)) ? '1 : final_est[ROOT_BITS-1:0];
		ans.steps = CAP_BITS'(n);
		return ans;
	endfunction

	function automatic logic [RAD_BITS-1:0] draw_radicand();
		logic [63:0] raw;
		int          w;
		raw = {$urandom, $urandom};
		w   = $urandom_range(1, RAD_BITS);
		case ($urandom_range(0, 19))
			0: begin
				return '0;
			end
			1, 2: begin
				return RAD_BITS'((64'd1 << w) - 64'd1);
			end
			3, 4, 5: begin
				return RAD_BITS'(raw) | (RAD_BITS'(1) << (RAD_BITS - 1));
			end
			default: begin
				return RAD_BITS'(raw & ((64'd1 << w) - 64'd1));
			end
		endcase
	endfunction

	// mostly back-to-back or short pauses, now and then a long one
	function automatic int draw_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				return 0;
			end
			6, 7, 8: begin
				return $urandom_range(1, 8);
			end
			default: begin
				return $urandom_range(20, 3000);
			end
		endcase
	endfunction

	task automatic queue_root(input logic [RAD_BITS-1:0] v, input int gap);
		pending_jobs.push_back('{kind: JOB_ROOT, value: v, index: REG_TOLERANCE, gap: gap});
	endtask

	task automatic queue_write(input reg_index_t idx, input logic [CFG_BITS-1:0] v);
		pending_jobs.push_back('{kind: JOB_WRITE, value: RAD_BITS'(v), index: idx, gap: 0});
	endtask

	// Driver. A command is held on start until busy is low; register writes wait for the
	// block to be idle with nothing outstanding. Each output gets one assignment per edge.
	always @(posedge clk or negedge arst_n) begin : drive
		logic next_start, next_wr;
		job_t job;
		if (!arst_n) begin
			start        <= 1'b0;
			radicand     <= '0;
			cfg_wr_en    <= 1'b0;
			cfg_index    <= REG_TOLERANCE;
			cfg_data     <= '0;
			gap_left     <= 0;
			quiet_cycles <= 0;
		end else begin
			next_start = 1'b0;
			next_wr    = 1'b0;
			if (start && !busy) begin
				awaited_roots.push_back(predict_root(radicand, tol_now, cap_now));
				cause_count[awaited_roots[$].cause]++;
				roots_taken++;
			end
			if (start && busy) begin
				next_start = 1'b1;                  // transaction still waiting to be taken
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_jobs.size() != 0) begin
				job = pending_jobs[0];
				if (job.kind == JOB_ROOT) begin
					next_start = 1'b1;
					radicand   <= job.value;
					gap_left   <= job.gap;
					pending_jobs.pop_front();
				end else if (busy || start || awaited_roots.size() != 0) begin
					quiet_cycles <= 0;
				end else if (quiet_cycles < SETTLE_CYCLES) begin
					quiet_cycles <= quiet_cycles + 1;
				end else begin
					next_wr = 1'b1;
					cfg_index <= job.index;
					cfg_data  <= job.value[CFG_BITS-1:0];
					if (job.index == REG_TOLERANCE)
						tol_now = job.value[TOL_BITS-1:0];
					else
						cap_now = job.value[CAP_BITS-1:0];
					settings++;
					quiet_cycles <= 0;
					pending_jobs.pop_front();
				end
			end
			// junk on the radicand whenever no command is presented
			if (!next_start && !(start && busy))
				radicand <= RAD_BITS'({$urandom, $urandom});
			start     <= next_start;
			cfg_wr_en <= next_wr;
		end
	end

	// Monitor and watchdog. The watchdog counts cycles with neither a command taken nor a
	// result strobed.
	always @(posedge clk or negedge arst_n) begin : watch
		root_answer_t want;
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (done) begin
				if (awaited_roots.size() == 0) begin
					$error("unexpected result: root %h steps %0d cap %b",
						root, steps_used, cap_reached);
					fails++;
				end else begin
					want = awaited_roots.pop_front();
					if (root !== want.root) begin
						$error("root: expected %h, got %h", want.root, root);
						fails++;
					end
					if (steps_used !== want.steps) begin
						$error("steps_used: expected %0d, got %0d", want.steps, steps_used);
						fails++;
					end
					if (cap_reached !== want.capped) begin
						$error("cap_reached: expected %b, got %b", want.capped, cap_reached);
						fails++;
					end
				end
			end
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("newton_square_root_core: mismatch");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int   p, k, no_gaps;
		logic [TOL_BITS-1:0] tol_pick;
		logic [CAP_BITS-1:0] cap_pick;

		// directed, reset registers: tolerance 0, cap 40
		queue_root('0, 0);                                   // zero radicand
		queue_root(RAD_BITS'(1), 0);                         // smallest, start far below root
		queue_root(RAD_BITS'(2), 3);
		queue_root(RAD_BITS'(16'h8000), 0);                  // 0.5
		queue_root(RAD_BITS'(32'h0001_0000), 0);             // 1.0
		queue_root(RAD_BITS'(32'h0004_0000), 1);             // exact root 2.0
		queue_root(RAD_BITS'(48'h0000_3039_0000), 0);
		queue_root(RAD_BITS'(48'hAAAA_AAAA_AAAA), 0);
		queue_root(RAD_BITS'(48'h5555_5555_5555), 0);
		queue_root(RAD_BITS'(1) << (RAD_BITS - 1), 0);
		queue_root('1, 0);                                   // largest radicand
		// one step only: large radicands leave the estimate above 32 bits
		queue_write(REG_ITER_CAP, CFG_BITS'(1));
		queue_root('1, 0);
		queue_root(RAD_BITS'(32'h0001_0000), 0);
		queue_root(RAD_BITS'(48'h0000_0001_2345), 0);
		// cap of zero behaves as one
		queue_write(REG_ITER_CAP, CFG_BITS'(0));
		queue_root('1, 0);
		queue_root(RAD_BITS'(7), 0);
		// widest tolerance, highest cap
		queue_write(REG_TOLERANCE, '1);
		queue_write(REG_ITER_CAP, CFG_BITS'(63));
		queue_root('1, 0);
		queue_root(RAD_BITS'(32'h0001_0000), 0);
		queue_root(RAD_BITS'(3), 0);

		// random phases, each under its own register setting
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0, 1: tol_pick = '0;
				2:    tol_pick = TOL_BITS'($urandom_range(1, 3));
				3:    tol_pick = TOL_BITS'($urandom_range(4, 64));
				4:    tol_pick = '1;
				default: tol_pick = TOL_BITS'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0:    cap_pick = '1;
				1:    cap_pick = CAP_BITS'($urandom_range(0, 6));
				default: cap_pick = CAP_BITS'($urandom_range(20, 63));
			endcase
			if (p == 0) begin
				tol_pick = '0;
				cap_pick = '1;
			end
			queue_write(REG_TOLERANCE, CFG_BITS'(tol_pick));
			queue_write(REG_ITER_CAP, CFG_BITS'(cap_pick));
			no_gaps = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_ITEMS; k++)
				queue_root(draw_radicand(), no_gaps ? 0 : draw_gap());
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_jobs.size() != 0 || awaited_roots.size() != 0 || start)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d radicands under %0d register settings: %0d zero, %0d converged,",
			roots_taken, settings, cause_count[STOP_ZERO], cause_count[STOP_CONVERGED]);
		$display("  %0d stopped on a rising estimate, %0d stopped at the cap",
			cause_count[STOP_RISING], cause_count[STOP_CAP]);
		if (fails == 0)
			$display("newton_square_root_core: match");
		else
			$display("newton_square_root_core: mismatch");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/nsr_pkg.sv
hw/rtl/nsr_divider.sv
hw/rtl/newton_square_root_core.sv
bench/tb_newton_square_root_core.sv
